/* rtl/pwt_pkg.sv */
// Shared types, codes and helpers for the protobuf wire tokenizer.
package pwt_pkg;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_FIXED   = 3'd4,
    PH_DRAIN   = 3'd5
  } phase_t;

  // token kinds
  localparam logic [2:0] TK_VARINT  = 3'd0;
  localparam logic [2:0] TK_LEN_HDR = 3'd1;
  localparam logic [2:0] TK_PAYLOAD = 3'd2;
  localparam logic [2:0] TK_FIXED   = 3'd3;
  localparam logic [2:0] TK_ERROR   = 3'd4;
  localparam logic [2:0] TK_END     = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_VARINT = 3'd1;
  localparam logic [2:0] ST_TAG_BIG    = 3'd2;
  localparam logic [2:0] ST_FIELD_ZERO = 3'd3;
  localparam logic [2:0] ST_BAD_WIRE   = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;
  localparam logic [2:0] ST_TOO_LONG   = 3'd6;

  // wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [3:0] LAST_VARINT_IDX = 4'd9;

  // byte as classified by the front end
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       cont;       // varint continuation bit
    logic       upper_set;  // any of bits 7..1 set
  } q_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [28:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        message_done;
  } result_t;

  // places a 7-bit varint group at its position in the 64-bit value
  function automatic logic [63:0] varint_shift(input logic [6:0] grp, input logic [3:0] idx);
    logic [69:0] wide;
    wide = 70'(grp) << (7 * idx);
    return wide[63:0];
  endfunction

endpackage

/* rtl/pwt_if.sv */
// Valid/ready channel interfaces for message bytes and tokens.
interface pwt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwt_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [28:0] field_number;
  logic [2:0]  wire_kind;
  logic [63:0] field_value;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic        message_done;

  modport source (output valid, output token_kind, output field_number, output wire_kind,
                  output field_value, output payload_byte, output status,
                  output message_done, input ready);
  modport sink (input valid, input token_kind, input field_number, input wire_kind,
                input field_value, input payload_byte, input status,
                input message_done, output ready);
endinterface

/* rtl/pwt_front.sv */
// Front end: accepts bytes, classifies them and queues them for the parser.
module pwt_front (
  input  logic              clk,
  input  logic              rst,
  pwt_byte_if.sink          byte_in,
  output logic              q_valid,
  output pwt_pkg::q_item_t  q_item,
  input  logic              q_pop
);
  import pwt_pkg::*;

  q_item_t    q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  q_item_t    item_in;

  assign byte_in.ready = (count != 2'd2);
  assign push = byte_in.valid && byte_in.ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_pop && q_valid;
  assign q_item = q_mem[rd_ptr];

  always_comb begin
    item_in.data      = byte_in.data_byte;
    item_in.last      = byte_in.last_byte;
    item_in.cont      = byte_in.data_byte[7];
    item_in.upper_set = (byte_in.data_byte[7:1] != 7'd0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/pwt_back.sv */
// Back end: wire-format parser state machine and token output register.
module pwt_back #(
  parameter int LENGTH_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  pwt_pkg::q_item_t  q_item,
  output logic              q_pop,
  input  logic [31:0]       length_limit,
  pwt_token_if.source       token_out
);
  import pwt_pkg::*;

  phase_t                 phase, phase_next;
  logic [63:0]            acc, acc_next;
  logic [3:0]             idx, idx_next;
  logic [28:0]            cur_field, cur_field_next;
  logic [2:0]             cur_wire, cur_wire_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [2:0]             held_error, held_error_next;

  logic                   step;
  logic                   emit;
  logic [2:0]             emit_kind;
  logic [2:0]             emit_status;
  logic                   fail;
  logic [2:0]             fail_code;
  logic                   tag_branch;
  logic                   tag_start;
  logic [63:0]            acc_base;
  logic [3:0]             idx_base;
  logic [63:0]            acc_fed;
  logic                   feed_bad;
  logic                   len_over;
  logic [LENGTH_BITS-1:0] bl_dec;

  logic                   out_valid;
  result_t                out_res;
  result_t                res;

  assign step  = q_valid && (!out_valid || token_out.ready);
  assign q_pop = step;

  assign tag_branch = !(phase == PH_VARINT || phase == PH_LENGTH || phase == PH_PAYLOAD ||
                        phase == PH_FIXED || phase == PH_DRAIN);
  assign tag_start  = (phase != PH_TAG) || (idx == 4'd0);
  assign acc_base   = (tag_branch && tag_start) ? 64'd0 : acc;
  assign idx_base   = (tag_branch && tag_start) ? 4'd0 : idx;
  assign acc_fed    = acc_base | varint_shift(q_item.data[6:0], idx_base);
  // the tenth byte may carry only bit 63
  assign feed_bad   = ((idx_base >= LAST_VARINT_IDX) && q_item.upper_set) ||
                      (idx_base > LAST_VARINT_IDX);
  assign len_over   = (acc_fed[63:32] != 32'd0) || (acc_fed[31:0] > length_limit);
  assign bl_dec     = (bytes_left != '0) ? bytes_left - LENGTH_BITS'(1) : '0;

  // next state
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    idx_next        = idx;
    cur_field_next  = cur_field;
    cur_wire_next   = cur_wire;
    bytes_left_next = bytes_left;
    held_error_next = held_error;
    emit            = 1'b0;
    emit_kind       = TK_VARINT;
    emit_status     = ST_OK;
    fail            = 1'b0;
    fail_code       = ST_OK;

    if (step) begin
      case (phase)
        PH_DRAIN: begin
          if (q_item.last) begin
            emit            = 1'b1;
            emit_kind       = TK_END;
            emit_status     = held_error;
            held_error_next = ST_OK;
            phase_next      = PH_TAG;
            acc_next        = 64'd0;
            idx_next        = 4'd0;
          end
        end
        PH_VARINT, PH_LENGTH: begin
          if (feed_bad) begin
            fail      = 1'b1;
            fail_code = ST_BAD_VARINT;
          end else if (q_item.cont) begin
            if (q_item.last) begin
              fail      = 1'b1;
              fail_code = ST_TRUNCATED;
            end else begin
              acc_next = acc_fed;
              idx_next = idx + 4'd1;
            end
          end else if (phase == PH_VARINT) begin
            emit       = 1'b1;
            emit_kind  = TK_VARINT;
            phase_next = PH_TAG;
            acc_next   = 64'd0;
            idx_next   = 4'd0;
          end else if (len_over) begin
            fail      = 1'b1;
            fail_code = ST_TOO_LONG;
          end else if ((acc_fed != 64'd0) && q_item.last) begin
            fail      = 1'b1;
            fail_code = ST_TRUNCATED;
          end else begin
            emit      = 1'b1;
            emit_kind = TK_LEN_HDR;
            acc_next  = 64'd0;
            idx_next  = 4'd0;
            if (acc_fed == 64'd0) begin
              phase_next = PH_TAG;
            end else begin
              // length fits: len_over bounds it below 2^LENGTH_BITS
              bytes_left_next = acc_fed[LENGTH_BITS-1:0];
              phase_next      = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next = bl_dec;
          if ((bl_dec != '0) && q_item.last) begin
            fail      = 1'b1;
            fail_code = ST_TRUNCATED;
          end else begin
            emit      = 1'b1;
            emit_kind = TK_PAYLOAD;
            if (bl_dec == '0) begin
              phase_next = PH_TAG;
              acc_next   = 64'd0;
              idx_next   = 4'd0;
            end
          end
        end
        PH_FIXED: begin
          bytes_left_next = bl_dec;
          if (bl_dec != '0) begin
            if (q_item.last) begin
              fail      = 1'b1;
              fail_code = ST_TRUNCATED;
            end
          end else begin
            emit       = 1'b1;
            emit_kind  = TK_FIXED;
            phase_next = PH_TAG;
            acc_next   = 64'd0;
            idx_next   = 4'd0;
          end
        end
        default: begin
          // tag bytes; unused codes restart a tag
          phase_next = PH_TAG;
          if (tag_start) begin
            cur_field_next = 29'd0;
            cur_wire_next  = WT_VARINT;
          end
          if (feed_bad) begin
            fail      = 1'b1;
            fail_code = ST_BAD_VARINT;
          end else if (q_item.cont) begin
            if (q_item.last) begin
              fail      = 1'b1;
              fail_code = ST_TRUNCATED;
            end else begin
              acc_next = acc_fed;
              idx_next = idx_base + 4'd1;
            end
          end else if (acc_fed[63:32] != 32'd0) begin
            fail      = 1'b1;
            fail_code = ST_TAG_BIG;
          end else begin
            cur_field_next = acc_fed[31:3];
            cur_wire_next  = acc_fed[2:0];
            acc_next       = 64'd0;
            idx_next       = 4'd0;
            if (acc_fed[31:3] == 29'd0) begin
              fail      = 1'b1;
              fail_code = ST_FIELD_ZERO;
            end else begin
              case (acc_fed[2:0])
                WT_VARINT: phase_next = PH_VARINT;
                WT_FIXED64: begin
                  phase_next      = PH_FIXED;
                  bytes_left_next = LENGTH_BITS'(8);
                end
                WT_LEN: phase_next = PH_LENGTH;
                WT_FIXED32: begin
                  phase_next      = PH_FIXED;
                  bytes_left_next = LENGTH_BITS'(4);
                end
                default: begin
                  fail      = 1'b1;
                  fail_code = ST_BAD_WIRE;
                end
              endcase
              if (!fail && q_item.last) begin
                fail      = 1'b1;
                fail_code = ST_TRUNCATED;
              end
            end
          end
        end
      endcase

      if (fail) begin
        emit            = 1'b1;
        emit_kind       = TK_ERROR;
        emit_status     = fail_code;
        phase_next      = q_item.last ? PH_TAG : PH_DRAIN;
        held_error_next = q_item.last ? ST_OK : fail_code;
        acc_next        = 64'd0;
        idx_next        = 4'd0;
      end
    end
  end

  // token built from this step's decision
  always_comb begin
    res.token_kind   = emit_kind;
    res.field_number = cur_field_next;
    res.wire_kind    = cur_wire_next;
    res.field_value  = (emit_kind == TK_VARINT || emit_kind == TK_LEN_HDR) ? acc_fed : 64'd0;
    res.payload_byte = (emit_kind == TK_PAYLOAD) ? q_item.data : 8'd0;
    res.status       = emit_status;
    res.message_done = q_item.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      acc        <= 64'd0;
      idx        <= 4'd0;
      cur_field  <= 29'd0;
      cur_wire   <= WT_VARINT;
      bytes_left <= '0;
      held_error <= ST_OK;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      acc        <= acc_next;
      idx        <= idx_next;
      cur_field  <= cur_field_next;
      cur_wire   <= cur_wire_next;
      bytes_left <= bytes_left_next;
      held_error <= held_error_next;
      if (step) begin
        out_valid <= emit;
      end else if (token_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res <= res;
    end
  end

  assign token_out.valid        = out_valid;
  assign token_out.token_kind   = out_res.token_kind;
  assign token_out.field_number = out_res.field_number;
  assign token_out.wire_kind    = out_res.wire_kind;
  assign token_out.field_value  = out_res.field_value;
  assign token_out.payload_byte = out_res.payload_byte;
  assign token_out.status       = out_res.status;
  assign token_out.message_done = out_res.message_done;

endmodule

/* rtl/protobuf_wire_tokenizer.sv */
// Streaming protobuf wire-format tokenizer, one message byte per item, at most one
// token per byte. It sustains one byte per clock unless the token receiver holds off a
// waiting token: a two-entry queue sits between the byte classifier and the parser, and
// the parser's token register is refilled in the same cycle it is drained, so the rate
// is set by the parser step. A token passes through the queue entry and then the token
// register after its byte is accepted.
// Tag bytes and unfinished varint or fixed bytes make no token; after an error all bytes
// are dropped until the last byte of the message, which returns an end token with the
// held error.
// Lengths above the smaller of max_field_length and 2^LENGTH_BITS-1 are errors.
// max_field_length resets to 3145728 and should only be written while idle.
module protobuf_wire_tokenizer #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  pwt_byte_if.sink    byte_in,
  pwt_token_if.source token_out
);
  import pwt_pkg::*;

  localparam logic [32:0] CAP_WIDE = (33'd1 << LENGTH_BITS) - 33'd1;
  localparam logic [31:0] LEN_CAP  = CAP_WIDE[31:0];

  logic [23:0] max_field_length;
  logic [31:0] length_limit;
  logic        q_valid;
  q_item_t     q_item;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_field_length <= 24'd3145728;
    end else if (cfg_we) begin
      max_field_length <= cfg_wdata;
    end
  end

  assign length_limit = ({8'd0, max_field_length} < LEN_CAP) ? {8'd0, max_field_length}
                                                              : LEN_CAP;

  pwt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pwt_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .length_limit (length_limit),
    .token_out    (token_out)
  );

endmodule

/* tb/protobuf_wire_tokenizer_checker.sv */
// Token checker for the protobuf wire tokenizer: predicts every token and compares it.
module protobuf_wire_tokenizer_checker #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  pwt_byte_if         byte_mon,
  pwt_token_if        token_mon,
  output int          mismatches,
  output int          tokens_pending,
  output int          tokens_checked,
  output int          error_tokens
);
  timeunit 1ns;
  timeprecision 1ps;
  import pwt_pkg::*;

  typedef enum logic [1:0] {GROUP_MORE, GROUP_DONE, GROUP_BAD} group_t;

  localparam logic [23:0] RESET_FIELD_LIMIT = 24'd3145728;
  localparam logic [63:0] LENGTH_CAP =
    (LENGTH_BITS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [31:0] FIXED64_BYTES = 32'd8;
  localparam logic [31:0] FIXED32_BYTES = 32'd4;

  phase_t      phase;
  logic [63:0] accum;
  logic [3:0]  group_idx;
  logic [28:0] field_no;
  logic [2:0]  wire_code;
  logic [31:0] bytes_owed;
  logic [2:0]  held_status;
  logic [23:0] length_limit;

  result_t pending_tokens[$];

  function automatic group_t take_group(input logic [7:0] b);
    if (group_idx >= LAST_VARINT_IDX && b[7:1] != 7'd0) return GROUP_BAD;
    if (group_idx > LAST_VARINT_IDX) return GROUP_BAD;
    accum |= 64'(b[6:0]) << (7 * group_idx);
    group_idx += 4'd1;
    return b[7] ? GROUP_MORE : GROUP_DONE;
  endfunction

  function automatic result_t make_token(input logic [2:0] kind, input logic [63:0] value,
                                         input logic [7:0] pbyte, input logic [2:0] st,
                                         input logic done);
    result_t t;
    t.token_kind   = kind;
    t.field_number = field_no;
    t.wire_kind    = wire_code;
    t.field_value  = value;
    t.payload_byte = pbyte;
    t.status       = st;
    t.message_done = done;
    return t;
  endfunction

  function automatic void restart_tag();
    phase     = PH_TAG;
    accum     = '0;
    group_idx = '0;
  endfunction

  // error token; on a non-final byte the rest of the message is dropped
  function automatic result_t raise_error(input logic [2:0] code, input logic last);
    result_t t;
    t = make_token(TK_ERROR, '0, '0, code, last);
    if (last) begin
      phase       = PH_TAG;
      held_status = ST_OK;
    end else begin
      phase       = PH_DRAIN;
      held_status = code;
    end
    accum     = '0;
    group_idx = '0;
    return t;
  endfunction

  // advances the decoder by one byte, returns 1 when the byte yields a token
  function automatic bit next_token(input logic [7:0] b, input logic last, output result_t t);
    group_t g;
    t = '0;
    case (phase)
      PH_DRAIN: begin
        if (!last) return 0;
        t = make_token(TK_END, '0, '0, held_status, 1'b1);
        held_status = ST_OK;
        restart_tag();
        return 1;
      end
      PH_VARINT, PH_LENGTH: begin
        g = take_group(b);
        if (g == GROUP_BAD) begin
          t = raise_error(ST_BAD_VARINT, last);
          return 1;
        end
        if (g == GROUP_MORE) begin
          if (!last) return 0;
          t = raise_error(ST_TRUNCATED, 1'b1);
          return 1;
        end
        if (phase == PH_VARINT) begin
          t = make_token(TK_VARINT, accum, '0, ST_OK, last);
          restart_tag();
          return 1;
        end
        // over-limit wins over truncation
        if (accum > LENGTH_CAP || accum > 64'(length_limit)) begin
          t = raise_error(ST_TOO_LONG, last);
          return 1;
        end
        if (accum != 64'd0 && last) begin
          t = raise_error(ST_TRUNCATED, 1'b1);
          return 1;
        end
        t = make_token(TK_LEN_HDR, accum, '0, ST_OK, last);
        if (accum == 64'd0) begin
          restart_tag();
        end else begin
          bytes_owed = accum[31:0];
          phase      = PH_PAYLOAD;
          accum      = '0;
          group_idx  = '0;
        end
        return 1;
      end
      PH_PAYLOAD: begin
        if (bytes_owed != 0) bytes_owed -= 32'd1;
        if (bytes_owed != 0 && last) begin
          t = raise_error(ST_TRUNCATED, 1'b1);
          return 1;
        end
        t = make_token(TK_PAYLOAD, '0, b, ST_OK, last);
        if (bytes_owed == 0) restart_tag();
        return 1;
      end
      PH_FIXED: begin
        if (bytes_owed != 0) bytes_owed -= 32'd1;
        if (bytes_owed != 0) begin
          if (!last) return 0;
          t = raise_error(ST_TRUNCATED, 1'b1);
          return 1;
        end
        t = make_token(TK_FIXED, '0, '0, ST_OK, last);
        restart_tag();
        return 1;
      end
      default: begin
        if (phase != PH_TAG || group_idx == 4'd0) begin
          restart_tag();
          field_no  = '0;
          wire_code = '0;
        end
        g = take_group(b);
        if (g == GROUP_BAD) begin
          t = raise_error(ST_BAD_VARINT, last);
          return 1;
        end
        if (g == GROUP_MORE) begin
          if (!last) return 0;
          t = raise_error(ST_TRUNCATED, 1'b1);
          return 1;
        end
        if (accum > 64'hFFFF_FFFF) begin
          t = raise_error(ST_TAG_BIG, last);
          return 1;
        end
        field_no  = accum[31:3];
        wire_code = accum[2:0];
        if (field_no == 29'd0) begin
          t = raise_error(ST_FIELD_ZERO, last);
          return 1;
        end
        accum     = '0;
        group_idx = '0;
        case (wire_code)
          WT_VARINT: phase = PH_VARINT;
          WT_FIXED64: begin
            phase      = PH_FIXED;
            bytes_owed = FIXED64_BYTES;
          end
          WT_LEN: phase = PH_LENGTH;
          WT_FIXED32: begin
            phase      = PH_FIXED;
            bytes_owed = FIXED32_BYTES;
          end
          default: begin
            t = raise_error(ST_BAD_WIRE, last);
            return 1;
          end
        endcase
        // tag completed by the final byte leaves the field unfinished
        if (last) begin
          t = raise_error(ST_TRUNCATED, 1'b1);
          return 1;
        end
        return 0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      phase          = PH_TAG;
      accum          = '0;
      group_idx      = '0;
      field_no       = '0;
      wire_code      = '0;
      bytes_owed     = '0;
      held_status    = ST_OK;
      length_limit   = RESET_FIELD_LIMIT;
      mismatches     = 0;
      tokens_checked = 0;
      error_tokens   = 0;
      pending_tokens.delete();
    end else begin
      if (token_mon.valid && token_mon.ready) begin
        got.token_kind   = token_mon.token_kind;
        got.field_number = token_mon.field_number;
        got.wire_kind    = token_mon.wire_kind;
        got.field_value  = token_mon.field_value;
        got.payload_byte = token_mon.payload_byte;
        got.status       = token_mon.status;
        got.message_done = token_mon.message_done;
        tokens_checked++;
        if (got.token_kind == TK_ERROR) error_tokens++;
        if (pending_tokens.size() == 0) begin
          $error("token_kind: expected no token, got %0d", got.token_kind);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", 64'(want.token_kind), 64'(got.token_kind));
          check_field("field_number", 64'(want.field_number), 64'(got.field_number));
          check_field("wire_kind", 64'(want.wire_kind), 64'(got.wire_kind));
          check_field("field_value", want.field_value, got.field_value);
          check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("message_done", 64'(want.message_done), 64'(got.message_done));
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        if (next_token(byte_mon.data_byte, byte_mon.last_byte, want))
          pending_tokens.insert(pending_tokens.size(), want);
      end
      if (cfg_we) length_limit = cfg_wdata;
    end
    tokens_pending <= pending_tokens.size();
  end

endmodule

/* tb/protobuf_wire_tokenizer_tb.sv */
// Top of the protobuf wire tokenizer testbench: clock, reset, message stimulus and verdict.
module protobuf_wire_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwt_pkg::*;

  localparam int          LONG_HOLD           = 120;
  localparam int          SETTLE_CYCLES       = 8;
  localparam int          WATCHDOG_CYCLES     = 4000;
  localparam logic [23:0] DEFAULT_FIELD_LIMIT = 24'd3145728;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [23:0] cfg_wdata;

  pwt_byte_if  byte_ch ();
  pwt_token_if token_ch ();

  int mismatches;
  int tokens_pending;
  int tokens_checked;
  int error_tokens;

  int          quiet_cycles;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          holds_requested;
  int          holds_served;
  int          bytes_sent;
  int          messages_sent;
  logic [23:0] field_limit;
  logic [7:0]  msg_bytes[$];

  protobuf_wire_tokenizer #(
    .LENGTH_BITS(24)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .byte_in  (byte_ch),
    .token_out(token_ch)
  );

  protobuf_wire_tokenizer_checker #(
    .LENGTH_BITS(24)
  ) token_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .byte_mon      (byte_ch),
    .token_mon     (token_ch),
    .mismatches    (mismatches),
    .tokens_pending(tokens_pending),
    .tokens_checked(tokens_checked),
    .error_tokens  (error_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // token receiver: random stall bursts plus the requested long hold
  initial begin : token_sink
    int span;
    token_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_served < holds_requested) begin
        token_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
      end else if ($urandom_range(99) < sink_idle_pct) begin
        token_ch.ready <= 1'b0;
        span = $urandom_range(1, 7);
        repeat (span) @(posedge clk);
      end
      token_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void append_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  function automatic int pad_groups();
    return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // LEB128 encoding, optionally padded with redundant groups (never past ten)
  function automatic void put_varint(input logic [63:0] v, input int pad);
    logic [63:0] rest;
    int          groups;
    rest   = v;
    groups = 1;
    while (rest > 64'd127) begin
      rest >>= 7;
      groups++;
    end
    groups += pad;
    if (groups > 10) groups = 10;
    rest = v;
    for (int i = 0; i < groups; i++) begin
      append_byte({(i < groups - 1) ? 1'b1 : 1'b0, rest[6:0]});
      rest >>= 7;
    end
  endfunction

  function automatic logic [28:0] random_field_no();
    case ($urandom_range(3))
      0: return 29'($urandom_range(1, 15));
      1: return 29'($urandom_range(16, 2047));
      2: return 29'h1FFF_FFFF;
      default: return 29'($urandom_range(1, 29'h1FFF_FFFF));
    endcase
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: begin
        w = $urandom_range(1, 64);
        return (w == 64) ? v : v & ((64'd1 << w) - 64'd1);
      end
    endcase
  endfunction

  function automatic void put_field();
    logic [28:0] fno;
    int          len;
    fno = random_field_no();
    case ($urandom_range(3))
      0: begin
        put_varint(64'({fno, WT_VARINT}), pad_groups());
        put_varint(random_value(), pad_groups());
      end
      1: begin
        put_varint(64'({fno, WT_FIXED64}), pad_groups());
        repeat (8) append_byte(8'($urandom));
      end
      2: begin
        len = $urandom_range(0, 12);
        if (len > field_limit) len = int'(field_limit);
        put_varint(64'({fno, WT_LEN}), pad_groups());
        put_varint(64'(len), pad_groups());
        repeat (len) append_byte(8'($urandom));
      end
      default: begin
        put_varint(64'({fno, WT_FIXED32}), pad_groups());
        repeat (4) append_byte(8'($urandom));
      end
    endcase
  endfunction

  // mostly well-formed messages; the rest truncated, malformed or noise
  function automatic void build_message();
    int          mix;
    int          keep;
    logic [63:0] big;
    logic [2:0]  wt;
    msg_bytes.delete();
    mix = $urandom_range(99);
    if (mix < 65) begin
      repeat ($urandom_range(1, 4)) put_field();
    end else if (mix < 73) begin
      repeat ($urandom_range(1, 3)) put_field();
      keep = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end else begin
      if ($urandom_range(1)) put_field();
      case (mix % 6)
        0: begin
          // ten-byte varint whose last byte is over one
          if ($urandom_range(1)) put_varint(64'({random_field_no(), WT_VARINT}), 0);
          repeat (9) append_byte(8'h80 | 8'($urandom_range(127)));
          append_byte(8'($urandom_range(2, 255)));
        end
        1: begin
          big = {$urandom, $urandom};
          big[32 + $urandom_range(31)] = 1'b1;
          put_varint(big, pad_groups());
        end
        2: put_varint(64'({29'd0, 3'($urandom_range(7))}), pad_groups());
        3: begin
          wt = 3'($urandom_range(3, 7));
          if (wt == WT_FIXED32) wt = 3'd6;
          put_varint(64'({random_field_no(), wt}), pad_groups());
        end
        4: begin
          put_varint(64'({random_field_no(), WT_LEN}), pad_groups());
          put_varint(64'(field_limit) + 64'd1 + ($urandom_range(1) ? 64'd0 : 64'($urandom)),
                     pad_groups());
        end
        default: repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
      endcase
      repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      bytes_sent++;
    end
    messages_sent++;
  endtask

  task automatic run_messages(input int byte_budget);
    int stop_at;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      build_message();
      send_message();
    end
  endtask

  // waits until every expected token is out and the pipeline has emptied
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_field_limit(input logic [23:0] value);
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    field_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last_byte = 1'b0;
    holds_requested   = 0;
    bytes_sent        = 0;
    messages_sent     = 0;
    field_limit       = DEFAULT_FIELD_LIMIT;
    src_idle_pct      = 20;
    sink_idle_pct     = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: plain varint, payload ending the message, fixed32, empty length field,
    // field zero on the final byte, unknown wire type with drain, cut fixed64
    msg_bytes = '{8'h08, 8'h96, 8'h01};
    send_message();
    msg_bytes = '{8'h12, 8'h02, 8'hAB, 8'hFF};
    send_message();
    msg_bytes = '{8'h15, 8'h00, 8'hFF, 8'h80, 8'h7F};
    send_message();
    msg_bytes = '{8'h1A, 8'h00, 8'h20, 8'h7F};
    send_message();
    msg_bytes = '{8'h00};
    send_message();
    msg_bytes = '{8'h0B, 8'h55};
    send_message();
    msg_bytes = '{8'h09, 8'h01, 8'h02};
    send_message();

    run_messages(280);

    settle();
    write_field_limit(24'd0);
    src_idle_pct  = 10;
    sink_idle_pct = 40;
    run_messages(150);

    settle();
    write_field_limit(24'hFF_FFFF);
    src_idle_pct = 0;
    holds_requested++;
    msg_bytes.delete();
    put_varint(64'({29'd3, WT_LEN}), 0);
    put_varint(64'd48, 0);
    repeat (48) append_byte(8'($urandom));
    send_message();
    src_idle_pct  = 30;
    sink_idle_pct = 10;
    run_messages(250);

    settle();
    write_field_limit(24'd6);
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    run_messages(250);

    settle();
    write_field_limit(24'($urandom));
    src_idle_pct  = 40;
    sink_idle_pct = 5;
    run_messages(250);

    // final stretch at full rate
    settle();
    write_field_limit(DEFAULT_FIELD_LIMIT);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_messages(250);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d bytes in %0d messages under six length limits, one long token stall",
             bytes_sent, messages_sent);
    $display("checked %0d tokens, %0d of them error tokens", tokens_checked, error_tokens);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
